[rtl/sha1s_pkg.sv]
// shared constants, types and round functions of the sha-1 stream hasher
`timescale 1ns / 1ps
package sha1s_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [31:0] H_INIT [0:4] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_00_19 = 32'h5A827999;
	localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
	localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
	localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;
	localparam logic [5:0] PAD_LIMIT   = 6'd56;
	localparam logic [6:0] LAST_ROUND  = 7'd79;

	// one 32-bit message word on its way to the compression core
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} word_entry_t;

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20) begin
			k = K_00_19;
		end else if (t < 7'd40) begin
			k = K_20_39;
		end else if (t < 7'd60) begin
			k = K_40_59;
		end else begin
			k = K_60_79;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
		end else if (t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

[rtl/sha1s_if.sv]
// valid/ready channels for message bytes and digests
`timescale 1ns / 1ps
interface sha1s_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sha1s_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	modport source (output valid, output digest_word0, output digest_word1,
		output digest_word2, output digest_word3, output digest_word4, input ready);
	modport sink (input valid, input digest_word0, input digest_word1,
		input digest_word2, input digest_word3, input digest_word4, output ready);
endinterface

[rtl/sha1s_front.sv]
// byte packer, length counter and padding sequencer
`timescale 1ns / 1ps
module sha1s_front (
	input  logic                     clk,
	input  logic                     arst_n,
	sha1s_byte_if.sink               msg,
	output sha1s_pkg::word_entry_t   push_data,
	output logic                     push_valid,
	input  logic                     push_ready
);

	logic [60:0] len_q;
	logic [60:0] len_nx;
	logic [23:0] acc_q;
	logic        pad_q;
	logic        first_q;
	logic        extra_q;
	logic [3:0]  idx_q;
	logic        accept;
	logic [63:0] bit_len;
	logic [31:0] pad_word;

	assign msg.ready = !pad_q && push_ready;
	assign accept    = msg.valid && msg.ready;
	assign len_nx    = len_q + 61'd1;
	assign bit_len   = {len_q, 3'b000};

	// partial word closed by the 0x80 marker
	always_comb begin
		case (len_q[1:0])
			2'd1:    pad_word = {acc_q[7:0], sha1s_pkg::PAD_BYTE, 16'h0000};
			2'd2:    pad_word = {acc_q[15:0], sha1s_pkg::PAD_BYTE, 8'h00};
			2'd3:    pad_word = {acc_q[23:0], sha1s_pkg::PAD_BYTE};
			default: pad_word = {sha1s_pkg::PAD_BYTE, 24'h000000};
		endcase
	end

	always_comb begin
		push_valid     = 1'b0;
		push_data.word = 32'h0;
		push_data.last = 1'b0;
		if (pad_q) begin
			push_valid     = 1'b1;
			push_data.last = (idx_q == sha1s_pkg::LEN_LO_WORD) && !extra_q;
			if (first_q) begin
				push_data.word = pad_word;
			end else if (!extra_q && idx_q == sha1s_pkg::LEN_HI_WORD) begin
				push_data.word = bit_len[63:32];
			end else if (!extra_q && idx_q == sha1s_pkg::LEN_LO_WORD) begin
				push_data.word = bit_len[31:0];
			end
		end else if (accept && len_q[1:0] == 2'd3) begin
			push_valid     = 1'b1;
			push_data.word = {acc_q, msg.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			extra_q <= 1'b0;
			idx_q   <= '0;
		end else if (pad_q) begin
			if (push_ready) begin
				first_q <= 1'b0;
				idx_q   <= idx_q + 4'd1;
				if (idx_q == sha1s_pkg::LEN_LO_WORD) begin
					if (extra_q) begin
						extra_q <= 1'b0;
					end else begin
						pad_q <= 1'b0;
						len_q <= '0;
					end
				end
			end
		end else if (accept) begin
			len_q <= len_nx;
			if (msg.last_byte) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
				idx_q   <= len_nx[5:2];
				extra_q <= (len_nx[5:0] >= sha1s_pkg::PAD_LIMIT);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= {acc_q[15:0], msg.data_byte};
		end
	end

	a_last_starts_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && msg.last_byte) |=> (pad_q && first_q))
		else $error("padding did not start after final byte");

endmodule

[rtl/sha1s_fifo.sv]
// short word queue between the byte front end and the compression core
`timescale 1ns / 1ps
module sha1s_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha1s_pkg::word_entry_t   push_data,
	input  logic                     push_valid,
	output logic                     push_ready,
	output sha1s_pkg::word_entry_t   pop_data,
	output logic                     pop_valid,
	input  logic                     pop_ready
);

	sha1s_pkg::word_entry_t             mem_q [sha1s_pkg::FIFO_DEPTH];
	logic [sha1s_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [sha1s_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [sha1s_pkg::FIFO_AW:0]        cnt_q;
	logic                               push_fire;
	logic                               pop_fire;

	assign push_ready = cnt_q != (sha1s_pkg::FIFO_AW + 1)'(sha1s_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + (sha1s_pkg::FIFO_AW)'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + (sha1s_pkg::FIFO_AW)'(1);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + (sha1s_pkg::FIFO_AW + 1)'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - (sha1s_pkg::FIFO_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (sha1s_pkg::FIFO_AW + 1)'(sha1s_pkg::FIFO_DEPTH))
		else $error("word queue overflow");

endmodule

[rtl/sha1s_core.sv]
// sha-1 compression core, one round per cycle, with digest output register
`timescale 1ns / 1ps
module sha1s_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha1s_pkg::word_entry_t   pop_data,
	input  logic                     pop_valid,
	output logic                     pop_ready,
	sha1s_digest_if.source           digest
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;

	logic [1:0]  state_q;
	logic [3:0]  wcnt_q;
	logic [6:0]  rnd_q;
	logic        last_q;
	logic        dvalid_q;
	logic [31:0] h_q   [0:4];
	logic [31:0] sum   [0:4];
	logic [31:0] dig_q [0:4];
	logic [31:0] win_q [0:15];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_next;
	logic [31:0] w_mix;
	logic [31:0] tmp;
	logic        pop_fire;
	logic        fin_go;

	assign pop_ready = state_q == ST_LOAD;
	assign pop_fire  = pop_valid && pop_ready;
	assign fin_go    = (state_q == ST_FIN) && (!last_q || !dvalid_q || digest.ready);

	// next schedule word, w[t+16] from the sliding window
	assign w_mix  = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_next = {w_mix[30:0], w_mix[31]};

	assign tmp = {a_q[26:0], a_q[31:27]} + sha1s_pkg::round_f(rnd_q, b_q, c_q, d_q)
		+ e_q + sha1s_pkg::round_k(rnd_q) + win_q[0];

	assign sum[0] = h_q[0] + a_q;
	assign sum[1] = h_q[1] + b_q;
	assign sum[2] = h_q[2] + c_q;
	assign sum[3] = h_q[3] + d_q;
	assign sum[4] = h_q[4] + e_q;

	assign digest.valid        = dvalid_q;
	assign digest.digest_word0 = dig_q[0];
	assign digest.digest_word1 = dig_q[1];
	assign digest.digest_word2 = dig_q[2];
	assign digest.digest_word3 = dig_q[3];
	assign digest.digest_word4 = dig_q[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			wcnt_q   <= '0;
			rnd_q    <= '0;
			last_q   <= 1'b0;
			dvalid_q <= 1'b0;
			h_q      <= sha1s_pkg::H_INIT;
		end else begin
			// a new digest may replace the one taken in the same cycle
			if (fin_go && last_q) begin
				dvalid_q <= 1'b1;
			end else if (digest.valid && digest.ready) begin
				dvalid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop_fire) begin
						wcnt_q <= wcnt_q + 4'd1;
						if (wcnt_q == 4'd15) begin
							last_q  <= pop_data.last;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1s_pkg::LAST_ROUND) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_LOAD;
						if (last_q) begin
							h_q <= sha1s_pkg::H_INIT;
						end else begin
							h_q <= sum;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= pop_data.word;
			if (wcnt_q == 4'd15) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_next;
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (fin_go && last_q) begin
			dig_q <= sum;
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= sha1s_pkg::LAST_ROUND))
		else $error("round counter out of range");

	a_final_restores_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && last_q) |=> (dvalid_q && h_q[0] == sha1s_pkg::H_INIT[0]
			&& h_q[4] == sha1s_pkg::H_INIT[4]))
		else $error("chain not reset after final block");

endmodule

[rtl/sha1_stream_hash.sv]
// top level of the streaming sha-1 hasher: byte front end, word queue, compression core
`timescale 1ns / 1ps
// a 64-byte block takes 16 word pops, 80 rounds and a chain update in the core, and
//   the 4-word queue lets the front end take 16 bytes while the rounds run; after the
//   final byte come up to 16 padding words (18 when the length spills into an extra
//   block), then each remaining block runs through the core to the digest
// reset: arst_n clears all control and restores the initial chain; no clearing pass
module sha1_stream_hash (
	input  logic            clk,
	input  logic            arst_n,
	sha1s_byte_if.sink      msg,
	sha1s_digest_if.source  digest
);

	// word requests between front end and queue
	sha1s_pkg::word_entry_t push_data;
	logic                   push_valid;
	logic                   push_ready;

	// word requests between queue and core
	sha1s_pkg::word_entry_t pop_data;
	logic                   pop_valid;
	logic                   pop_ready;

	// front end: packs bytes big-endian into words, counts the length and,
	// after the final byte, appends the 0x80 marker, zeros and the bit length;
	// no byte is taken while the padding words go out
	sha1s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// short queue so the front end keeps taking bytes while the core runs rounds
	sha1s_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// back end: loads 16 words, runs 80 rounds, folds into the chain and,
	// on the final block of a message, latches the digest and restarts the chain
	sha1s_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.digest    (digest)
	);

endmodule

[tb/sha1_digest_monitor.sv]
// sha-1 digest predictor and checker that watches the byte and digest channels
`timescale 1ns / 1ps
module sha1_digest_monitor (
	input  logic    clk,
	input  logic    arst_n,
	sha1s_byte_if   msg,
	sha1s_digest_if digest,
	output int      errors,
	output int      pending,
	output int      checked
);

	// word 0 sits in the low slot
	typedef logic [4:0][31:0] digest_t;

	logic [31:0] chain_h [5];
	logic [7:0]  block_buf [64];
	logic [60:0] byte_count;
	digest_t     digests_due [$];
	digest_t     got_digest;
	digest_t     want_digest;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		end
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			// rolling 16-word schedule
			if (r >= 16) begin
				w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^
					w[r % 16], 1);
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1s_pkg::K_00_19;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1s_pkg::K_20_39;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1s_pkg::K_40_59;
			end else begin
				f = b ^ c ^ d;
				k = sha1s_pkg::K_60_79;
			end
			t = rotl(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] = chain_h[0] + a;
		chain_h[1] = chain_h[1] + b;
		chain_h[2] = chain_h[2] + c;
		chain_h[3] = chain_h[3] + d;
		chain_h[4] = chain_h[4] + e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] data, input logic fin);
		int pos;
		logic [63:0] bit_len;
		block_buf[byte_count[5:0]] = data;
		byte_count = byte_count + 61'd1;
		if (byte_count[5:0] == 6'd0) begin
			compress_block();
		end
		if (fin) begin
			pos = int'(byte_count[5:0]);
			block_buf[pos] = sha1s_pkg::PAD_BYTE;
			for (int i = pos + 1; i < 64; i++) begin
				block_buf[i] = 8'h00;
			end
			// no room for the length field: it goes into an extra block
			if (pos >= 56) begin
				compress_block();
				for (int i = 0; i < 64; i++) begin
					block_buf[i] = 8'h00;
				end
			end
			bit_len = {byte_count, 3'b000};
			for (int i = 0; i < 8; i++) begin
				block_buf[63 - i] = bit_len[8*i +: 8];
			end
			compress_block();
			digests_due.push_back({chain_h[4], chain_h[3], chain_h[2], chain_h[1], chain_h[0]});
			chain_h = sha1s_pkg::H_INIT;
			byte_count = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_h = sha1s_pkg::H_INIT;
			byte_count = '0;
			digests_due.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (msg.valid && msg.ready) begin
				absorb_byte(msg.data_byte, msg.last_byte);
			end
			if (digest.valid && digest.ready) begin
				got_digest = {digest.digest_word4, digest.digest_word3, digest.digest_word2,
					digest.digest_word1, digest.digest_word0};
				if (digests_due.size() == 0) begin
					$error("digest with no message outstanding: %h", got_digest);
					errors++;
				end else begin
					want_digest = digests_due.pop_front();
					checked++;
					for (int i = 0; i < 5; i++) begin
						if (got_digest[i] !== want_digest[i]) begin
							$error("digest_word%0d: expected %h, actual %h", i,
								want_digest[i], got_digest[i]);
							errors++;
						end
					end
				end
			end
			pending = digests_due.size();
		end
	end

endmodule

[tb/tb_sha1_stream_hash.sv]
// top of the sha-1 stream hasher testbench: clock, reset, message stimulus and verdict
`timescale 1ns / 1ps
module tb_sha1_stream_hash;

	// run-wide limit, set with a wide margin over what the messages need
	localparam int CYCLE_LIMIT    = 400000;
	// longest tail after the final byte: 18 padding words plus two blocks in the core
	localparam int DRAIN_CYCLES   = 250;
	localparam int TARGET_BYTES   = 550;
	localparam int TARGET_DIGESTS = 40;
	// from here on both sides run without gaps
	localparam int QUIET_AFTER    = 470;
	// lengths around the padding limit and the block boundaries
	localparam int BOUNDARY_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	logic clk;
	logic arst_n;

	int errors;
	int pending;
	int checked;
	int cycle_count;
	int bytes_sent;
	int msgs_sent;
	int longest_msg;
	bit quiet;

	sha1s_byte_if   msg_ch ();
	sha1s_digest_if digest_ch ();

	sha1_stream_hash i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	// predicts every digest and compares it as it leaves the block
	sha1_digest_monitor i_monitor (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg_ch),
		.digest  (digest_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// hard stop in case the block hangs or drops a digest
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_sha1_stream_hash: errors");
		$finish;
	end

	// digest side: ready runs broken by stall bursts, both of random length,
	// no stalls once the run is in its quiet tail
	initial begin
		digest_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			digest_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			if (!quiet) begin
				digest_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
		end
	end

	// one byte request; an idle burst may come first, valid stays up between
	// back-to-back requests so it only gets one update per falling edge
	task automatic send_byte(input logic [7:0] data, input logic fin);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		msg_ch.valid     <= 1'b1;
		msg_ch.data_byte <= data;
		msg_ch.last_byte <= fin;
		do begin
			@(posedge clk);
		end while (!msg_ch.ready);
		bytes_sent++;
		if (fin) begin
			msgs_sent++;
		end
		quiet = (bytes_sent >= QUIET_AFTER);
	endtask

	// whole message of random bytes, last flag on the final one
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom), i == len - 1);
		end
		if (len > longest_msg) begin
			longest_msg = len;
		end
	endtask

	// hold the sender back until every outstanding digest has come out
	task automatic drain_digests();
		@(negedge clk);
		msg_ch.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		msg_ch.valid     = 1'b0;
		msg_ch.data_byte = 8'h00;
		msg_ch.last_byte = 1'b0;
		quiet            = 1'b0;
		bytes_sent       = 0;
		msgs_sent        = 0;
		longest_msg      = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-byte messages at both data extremes
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// the classic three-byte message
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b1);
		// alternating all-zero and all-one bytes, mostly steps without a result
		for (int i = 0; i < 8; i++) begin
			send_byte(i[0] ? 8'hFF : 8'h00, i == 7);
		end
		if (longest_msg < 8) begin
			longest_msg = 8;
		end
		drain_digests();

		// padding that just fits, padding that spills into an extra block,
		// and a message that fills exactly one block
		send_message(55);
		send_message(56);
		send_message(64);

		// mostly short messages so digests come often, now and then one near a
		// block boundary
		while (bytes_sent < TARGET_BYTES || msgs_sent < TARGET_DIGESTS) begin
			if ($urandom_range(0, 11) == 0) begin
				send_message(BOUNDARY_LEN[$urandom_range(0, 9)]);
			end else begin
				send_message($urandom_range(1, 12));
			end
		end

		drain_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d message bytes in %0d messages, longest %0d bytes",
			bytes_sent, msgs_sent, longest_msg);
		$display("%0d digests compared word by word, %0d mismatches", checked, errors);
		if (errors == 0) begin
			$display("tb_sha1_stream_hash: clean");
		end else begin
			$display("tb_sha1_stream_hash: errors");
		end
		$finish;
	end

endmodule

[sha1_stream_hash.f]
rtl/sha1s_pkg.sv
rtl/sha1s_if.sv
rtl/sha1s_front.sv
rtl/sha1s_fifo.sv
rtl/sha1s_core.sv
rtl/sha1_stream_hash.sv
tb/sha1_digest_monitor.sv
tb/tb_sha1_stream_hash.sv
